@@ src/bpp_pkg.sv @@
// Shared constants, types and fixed-point helpers of the Boris particle pusher.
package bpp_pkg;

  localparam int FRAC_BITS = 16;
  localparam int TAG_BITS  = 16;
  localparam logic [15:0] TAG_MASK =
    (TAG_BITS >= 16) ? 16'hFFFF : 16'(((32'd1 << TAG_BITS) - 32'd1));

  // Denominator of the rotation scale is 2^F plus three squares
  localparam int DEN_W = 64 - FRAC_BITS;
  // Quotient bits of the scale division and the numerator width
  localparam int QW = 33;
  localparam int NW = 66;

  // Configuration register indexes
  localparam logic [7:0] CFG_MODE  = 8'd0;
  localparam logic [7:0] CFG_ALPHA = 8'd1;
  localparam logic [7:0] CFG_DT    = 8'd2;
  localparam logic [7:0] CFG_LEN   = 8'd3;

  // Payload that rides alongside the scale division
  typedef struct packed {
    logic [15:0]      tag;
    logic [31:0]      pos;
    logic [2:0][31:0] u;
    logic [2:0][31:0] p;
    logic [2:0][31:0] k;
    logic [31:0]      nvx_e;
    logic [31:0]      vy;
    logic [31:0]      vz;
    logic             mode;
    logic [2:0]       tneg;
  } side_t;

  // Rounded product: floor((prod + 2^(sh-1)) / 2^sh)
  function automatic logic signed [63:0] rnd(input logic signed [63:0] prod, input int sh);
    return (prod + (64'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  // Clamp to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

endpackage

@@ src/bpp_front.sv @@
// Front pipeline: kicks, rotation vector, first cross step and division operands.
module bpp_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [15:0]                 in_tag,
  input  logic signed [31:0]          in_pos,
  input  logic signed [31:0]          in_vel_x,
  input  logic signed [31:0]          in_vel_y,
  input  logic signed [31:0]          in_vel_z,
  input  logic signed [31:0]          e_x,
  input  logic signed [31:0]          e_y,
  input  logic signed [31:0]          e_z,
  input  logic signed [31:0]          b_x,
  input  logic signed [31:0]          b_y,
  input  logic signed [31:0]          b_z,
  input  logic                        mode,
  input  logic signed [31:0]          alpha,
  output logic                        d_valid,
  output logic [bpp_pkg::DEN_W-1:0]   d_den,
  output logic [2:0][bpp_pkg::NW-1:0] d_num,
  output bpp_pkg::side_t              d_side
);
  import bpp_pkg::*;

  // Stage A: raw field products
  logic               a_valid;
  logic signed [63:0] a_pe [3];
  logic signed [63:0] a_pb [3];
  logic signed [31:0] a_v [3];
  logic signed [31:0] a_pos;
  logic [15:0]        a_tag;
  logic               a_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
    end
    if (en) begin
      a_pe[0] <= alpha * e_x;
      a_pe[1] <= alpha * e_y;
      a_pe[2] <= alpha * e_z;
      a_pb[0] <= alpha * b_x;
      a_pb[1] <= alpha * b_y;
      a_pb[2] <= alpha * b_z;
      a_v[0]  <= in_vel_x;
      a_v[1]  <= in_vel_y;
      a_v[2]  <= in_vel_z;
      a_pos   <= in_pos;
      a_tag   <= in_tag;
      a_mode  <= mode;
    end
  end

  // Stage B: kick, half-kicked velocity, rotation vector
  logic               b_valid;
  logic signed [31:0] b_k [3];
  logic signed [31:0] b_t [3];
  logic signed [31:0] b_u [3];
  logic signed [31:0] b_vy, b_vz, b_nvxe, b_pos;
  logic [15:0]        b_tag;
  logic               b_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= a_valid;
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        b_k[i] <= sat32(rnd(a_pe[i], FRAC_BITS));
        b_t[i] <= sat32(rnd(a_pb[i], FRAC_BITS));
        b_u[i] <= sat32(64'(a_v[i]) + 64'(sat32(rnd(a_pe[i], FRAC_BITS))));
      end
      b_nvxe <= sat32(64'(a_v[0]) + rnd(a_pe[0], FRAC_BITS - 1));
      b_vy   <= a_v[1];
      b_vz   <= a_v[2];
      b_pos  <= a_pos;
      b_tag  <= a_tag;
      b_mode <= a_mode;
    end
  end

  // Stage C: squares of T and the u x T products
  logic               c_valid;
  logic signed [63:0] c_tt [3];
  logic signed [63:0] c_x [6];
  logic signed [31:0] c_k [3];
  logic signed [31:0] c_t [3];
  logic signed [31:0] c_u [3];
  logic signed [31:0] c_vy, c_vz, c_nvxe, c_pos;
  logic [15:0]        c_tag;
  logic               c_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (en) begin
      c_valid <= b_valid;
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        c_tt[i] <= b_t[i] * b_t[i];
        c_k[i]  <= b_k[i];
        c_t[i]  <= b_t[i];
        c_u[i]  <= b_u[i];
      end
      c_x[0] <= b_u[1] * b_t[2];
      c_x[1] <= b_u[2] * b_t[1];
      c_x[2] <= b_u[2] * b_t[0];
      c_x[3] <= b_u[0] * b_t[2];
      c_x[4] <= b_u[0] * b_t[1];
      c_x[5] <= b_u[1] * b_t[0];
      c_vy   <= b_vy;
      c_vz   <= b_vz;
      c_nvxe <= b_nvxe;
      c_pos  <= b_pos;
      c_tag  <= b_tag;
      c_mode <= b_mode;
    end
  end

  // Stage D: denominator, numerators, first cross step
  logic signed [63:0] den_sum;
  logic [DEN_W-1:0]   den_w;
  logic [32:0]        mag [3];

  always_comb begin
    den_sum = (64'sd1 <<< FRAC_BITS) + rnd(c_tt[0], FRAC_BITS)
            + rnd(c_tt[1], FRAC_BITS) + rnd(c_tt[2], FRAC_BITS);
    den_w = den_sum[DEN_W-1:0];
    for (int i = 0; i < 3; i++) begin
      mag[i] = c_t[i][31] ? (33'd0 - {1'b1, c_t[i]}) : {1'b0, c_t[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (en) begin
      d_valid <= c_valid;
    end
    if (en) begin
      d_den <= den_w;
      for (int i = 0; i < 3; i++) begin
        d_num[i]       <= (NW'(mag[i]) << (FRAC_BITS + 1)) + NW'(den_w >> 1);
        d_side.u[i]    <= c_u[i];
        d_side.k[i]    <= c_k[i];
        d_side.tneg[i] <= c_t[i][31];
      end
      d_side.p[0] <= sat32(64'(c_u[0]) + rnd(c_x[0], FRAC_BITS) - rnd(c_x[1], FRAC_BITS));
      d_side.p[1] <= sat32(64'(c_u[1]) + rnd(c_x[2], FRAC_BITS) - rnd(c_x[3], FRAC_BITS));
      d_side.p[2] <= sat32(64'(c_u[2]) + rnd(c_x[4], FRAC_BITS) - rnd(c_x[5], FRAC_BITS));
      d_side.nvx_e <= c_nvxe;
      d_side.vy    <= c_vy;
      d_side.vz    <= c_vz;
      d_side.pos   <= c_pos;
      d_side.tag   <= c_tag;
      d_side.mode  <= c_mode;
    end
  end

endmodule

@@ src/bpp_div.sv @@
// Pipelined restoring divider, three lanes sharing one denominator, one quotient bit per stage.
module bpp_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        d_valid,
  input  logic [bpp_pkg::DEN_W-1:0]   d_den,
  input  logic [2:0][bpp_pkg::NW-1:0] d_num,
  input  bpp_pkg::side_t              d_side,
  output logic                        q_valid,
  output logic [2:0][bpp_pkg::QW-1:0] q_quo,
  output bpp_pkg::side_t              q_side
);
  import bpp_pkg::*;

  logic                   valid [QW+1];
  logic [DEN_W-1:0]       den   [QW+1];
  logic [2:0][DEN_W:0]    rem   [QW+1];
  logic [2:0][QW-1:0]     nlo   [QW+1];
  logic [2:0][QW-1:0]     quo   [QW+1];
  side_t                  side  [QW+1];

  // Load: upper numerator bits start the remainder
  always_ff @(posedge clk) begin
    if (rst) begin
      valid[0] <= 1'b0;
    end else if (en) begin
      valid[0] <= d_valid;
    end
    if (en) begin
      den[0]  <= d_den;
      side[0] <= d_side;
      for (int l = 0; l < 3; l++) begin
        rem[0][l] <= (DEN_W + 1)'(d_num[l][NW-1:QW]);
        nlo[0][l] <= d_num[l][QW-1:0];
        quo[0][l] <= '0;
      end
    end
  end

  // One quotient bit per stage
  for (genvar s = 1; s <= QW; s++) begin : g_stage
    logic [2:0][DEN_W:0] trial;
    always_comb begin
      for (int l = 0; l < 3; l++) begin
        trial[l] = {rem[s-1][l][DEN_W-1:0], nlo[s-1][l][QW-1]};
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        valid[s] <= 1'b0;
      end else if (en) begin
        valid[s] <= valid[s-1];
      end
      if (en) begin
        den[s]  <= den[s-1];
        side[s] <= side[s-1];
        for (int l = 0; l < 3; l++) begin
          nlo[s][l] <= {nlo[s-1][l][QW-2:0], 1'b0};
          if (trial[l] >= {1'b0, den[s-1]}) begin
            rem[s][l] <= trial[l] - {1'b0, den[s-1]};
            quo[s][l] <= {quo[s-1][l][QW-2:0], 1'b1};
          end else begin
            rem[s][l] <= trial[l];
            quo[s][l] <= {quo[s-1][l][QW-2:0], 1'b0};
          end
        end
      end
    end
  end

  assign q_valid = valid[QW];
  assign q_quo   = quo[QW];
  assign q_side  = side[QW];

endmodule

@@ src/bpp_back.sv @@
// Back pipeline: rotation scale, second cross step, final kick and position update.
module bpp_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        q_valid,
  input  logic [2:0][bpp_pkg::QW-1:0] q_quo,
  input  bpp_pkg::side_t              q_side,
  input  logic [30:0]                 dt,
  input  logic [30:0]                 len,
  output logic                        out_valid,
  output logic [15:0]                 out_tag,
  output logic signed [31:0]          new_pos,
  output logic signed [31:0]          new_vel_x,
  output logic signed [31:0]          new_vel_y,
  output logic signed [31:0]          new_vel_z
);
  import bpp_pkg::*;

  // Stage E: signed, saturated scale
  logic               e_valid;
  logic signed [31:0] e_s [3];
  side_t              e_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (en) begin
      e_valid <= q_valid;
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        e_s[i] <= q_side.tneg[i] ? sat32(64'sd0 - $signed(64'(q_quo[i])))
                                 : sat32($signed(64'(q_quo[i])));
      end
      e_side <= q_side;
    end
  end

  // Stage F: p x S products
  logic               f_valid;
  logic signed [63:0] f_x [6];
  side_t              f_side;
  logic signed [31:0] px, py, pz;

  assign px = $signed(e_side.p[0]);
  assign py = $signed(e_side.p[1]);
  assign pz = $signed(e_side.p[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (en) begin
      f_valid <= e_valid;
    end
    if (en) begin
      f_x[0] <= py * e_s[2];
      f_x[1] <= pz * e_s[1];
      f_x[2] <= pz * e_s[0];
      f_x[3] <= px * e_s[2];
      f_x[4] <= px * e_s[1];
      f_x[5] <= py * e_s[0];
      f_side <= e_side;
    end
  end

  // Stage G: second cross step, second half kick, mode select
  logic               g_valid;
  logic signed [31:0] g_v [3];
  logic signed [31:0] g_pos;
  logic [15:0]        g_tag;
  logic signed [31:0] w [3];

  always_comb begin
    w[0] = sat32(64'($signed(f_side.u[0])) + rnd(f_x[0], FRAC_BITS) - rnd(f_x[1], FRAC_BITS));
    w[1] = sat32(64'($signed(f_side.u[1])) + rnd(f_x[2], FRAC_BITS) - rnd(f_x[3], FRAC_BITS));
    w[2] = sat32(64'($signed(f_side.u[2])) + rnd(f_x[4], FRAC_BITS) - rnd(f_x[5], FRAC_BITS));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      g_valid <= 1'b0;
    end else if (en) begin
      g_valid <= f_valid;
    end
    if (en) begin
      if (f_side.mode) begin
        for (int i = 0; i < 3; i++) begin
          g_v[i] <= sat32(64'(w[i]) + 64'($signed(f_side.k[i])));
        end
      end else begin
        g_v[0] <= $signed(f_side.nvx_e);
        g_v[1] <= $signed(f_side.vy);
        g_v[2] <= $signed(f_side.vz);
      end
      g_pos <= $signed(f_side.pos);
      g_tag <= f_side.tag;
    end
  end

  // Stage H: displacement product
  logic               h_valid;
  logic signed [63:0] h_prod;
  logic signed [31:0] h_v [3];
  logic signed [31:0] h_pos;
  logic [15:0]        h_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      h_valid <= 1'b0;
    end else if (en) begin
      h_valid <= g_valid;
    end
    if (en) begin
      h_prod <= $signed({1'b0, dt}) * g_v[0];
      h_v    <= g_v;
      h_pos  <= g_pos;
      h_tag  <= g_tag;
    end
  end

  // Stage I: advance, reflect once, saturate
  logic signed [63:0] pnew, pref, len_s;

  always_comb begin
    len_s = $signed(64'(len));
    pnew  = 64'(h_pos) + rnd(h_prod, FRAC_BITS);
    if (pnew < 64'sd0) begin
      pref = 64'sd0 - pnew;
    end else if (pnew > len_s) begin
      pref = (len_s <<< 1) - pnew;
    end else begin
      pref = pnew;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= h_valid;
    end
    if (en) begin
      new_pos   <= sat32(pref);
      new_vel_x <= h_v[0];
      new_vel_y <= h_v[1];
      new_vel_z <= h_v[2];
      out_tag   <= h_tag & TAG_MASK;
    end
  end

endmodule

@@ src/boris_particle_pusher_core.sv @@
// Top level of the Boris particle pusher: configuration registers and pipeline.
// One particle is accepted every cycle while the output is not stalled; it passes
// four front stages, a 34-stage divider (a load stage, then one quotient bit of the
// rotation scale per stage) and five back stages. The whole pipeline stalls as
// one while a result waits at the output. Configuration writes are taken at
// any time, and should be made only while no particle is in flight.
module boris_particle_pusher_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        in_tag,
  input  logic signed [31:0] in_pos,
  input  logic signed [31:0] in_vel_x,
  input  logic signed [31:0] in_vel_y,
  input  logic signed [31:0] in_vel_z,
  input  logic signed [31:0] e_x,
  input  logic signed [31:0] e_y,
  input  logic signed [31:0] e_z,
  input  logic signed [31:0] b_x,
  input  logic signed [31:0] b_y,
  input  logic signed [31:0] b_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        out_tag,
  output logic signed [31:0] new_pos,
  output logic signed [31:0] new_vel_x,
  output logic signed [31:0] new_vel_y,
  output logic signed [31:0] new_vel_z
);
  import bpp_pkg::*;

  logic               magnetic_mode;
  logic signed [31:0] half_accel_coeff;
  logic [30:0]        time_step;
  logic [30:0]        domain_length;

  // Register writes; unknown indexes drop
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      magnetic_mode    <= 1'b1;
      half_accel_coeff <= '0;
      time_step        <= 31'd6554;
      domain_length    <= 31'd4194304;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MODE:  magnetic_mode    <= cfg_data[0];
        CFG_ALPHA: half_accel_coeff <= cfg_data;
        CFG_DT:    time_step        <= cfg_data[30:0];
        CFG_LEN:   domain_length    <= cfg_data[30:0];
        default:   ;
      endcase
    end
  end

  // Advance the pipeline unless the output holds an untaken transfer
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  logic                   d_valid;
  logic [DEN_W-1:0]       d_den;
  logic [2:0][NW-1:0]     d_num;
  side_t                  d_side;
  logic                   q_valid;
  logic [2:0][QW-1:0]     q_quo;
  side_t                  q_side;

  bpp_front u_front (
    .clk, .rst, .en, .in_valid,
    .in_tag, .in_pos, .in_vel_x, .in_vel_y, .in_vel_z,
    .e_x, .e_y, .e_z, .b_x, .b_y, .b_z,
    .mode(magnetic_mode), .alpha(half_accel_coeff),
    .d_valid, .d_den, .d_num, .d_side
  );

  bpp_div u_div (
    .clk, .rst, .en, .d_valid, .d_den, .d_num, .d_side,
    .q_valid, .q_quo, .q_side
  );

  bpp_back u_back (
    .clk, .rst, .en, .q_valid, .q_quo, .q_side,
    .dt(time_step), .len(domain_length),
    .out_valid, .out_tag, .new_pos, .new_vel_x, .new_vel_y, .new_vel_z
  );

endmodule

@@ src/bpp_checker.sv @@
// Port-level checks of the particle pusher, bound to the top level.
module bpp_checker (
  input logic        clk,
  input logic        rst,
  input logic        cfg_ready,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] new_pos,
  input logic [31:0] new_vel_x
);

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // Input is taken exactly when the output can move
  a_in_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output stall");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(new_pos) && $stable(new_vel_x))
    else $error("stalled result changed");

  // Configuration transfers are never refused
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("configuration port not ready");

endmodule

bind boris_particle_pusher_core bpp_checker u_bpp_checker (
  .clk, .rst, .cfg_ready, .in_ready, .out_valid, .out_ready, .new_pos, .new_vel_x
);

@@ dv/boris_particle_pusher_core_tb.sv @@
// Self-checking testbench of the Boris particle pusher core with its own model.
`timescale 1ns / 1ps

module boris_particle_pusher_core_tb;
  import bpp_pkg::*;

  typedef struct {
    logic [15:0] tag;
    logic signed [31:0] pos, vx, vy, vz, ex, ey, ez, bx, by, bz;
  } particle_t;

  typedef struct {
    logic [15:0] tag;
    logic signed [31:0] pos, vx, vy, vz;
  } pushed_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [7:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [15:0] in_tag = '0;
  logic signed [31:0] in_pos = '0, in_vel_x = '0, in_vel_y = '0, in_vel_z = '0;
  logic signed [31:0] e_x = '0, e_y = '0, e_z = '0, b_x = '0, b_y = '0, b_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [15:0] out_tag;
  logic signed [31:0] new_pos, new_vel_x, new_vel_y, new_vel_z;

  // Model copy of the registers
  logic mdl_mode;
  logic signed [63:0] mdl_alpha, mdl_dt, mdl_len;

  pushed_t pushed_q[$];
  int send_idle_pct, recv_idle_pct;
  int n_sent, n_checked, n_errors;

  boris_particle_pusher_core u_top (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic signed [63:0] clamp(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Rounded fixed-point product, half up, with a given scale shift
  function automatic logic signed [63:0] fxmul(input logic signed [63:0] a,
                                               input logic signed [63:0] b,
                                               input int sh);
    logic signed [63:0] p;
    p = a * b + (64'sd1 <<< (sh - 1));
    return p >>> sh;
  endfunction

  function automatic logic signed [63:0] rot_scale(input logic signed [63:0] t,
                                                   input logic signed [63:0] den);
    logic [63:0] mag, num, q;
    mag = (t < 0) ? -t : t;
    num = mag << (FRAC_BITS + 1);
    q = (num + (den >> 1)) / den;
    return clamp((t < 0) ? -$signed(q) : $signed(q));
  endfunction

  function automatic pushed_t push_particle(input particle_t pt);
    pushed_t r;
    logic signed [63:0] kx, ky, kz, ux, uy, uz, tx, ty, tz, den, sx, sy, sz;
    logic signed [63:0] px, py, pz, wx, wy, wz, nvx, nvy, nvz, p;
    if (mdl_mode) begin
      kx = clamp(fxmul(mdl_alpha, pt.ex, FRAC_BITS));
      ky = clamp(fxmul(mdl_alpha, pt.ey, FRAC_BITS));
      kz = clamp(fxmul(mdl_alpha, pt.ez, FRAC_BITS));
      ux = clamp(pt.vx + kx);
      uy = clamp(pt.vy + ky);
      uz = clamp(pt.vz + kz);
      tx = clamp(fxmul(mdl_alpha, pt.bx, FRAC_BITS));
      ty = clamp(fxmul(mdl_alpha, pt.by, FRAC_BITS));
      tz = clamp(fxmul(mdl_alpha, pt.bz, FRAC_BITS));
      den = (64'sd1 <<< FRAC_BITS) + fxmul(tx, tx, FRAC_BITS) + fxmul(ty, ty, FRAC_BITS)
            + fxmul(tz, tz, FRAC_BITS);
      sx = rot_scale(tx, den);
      sy = rot_scale(ty, den);
      sz = rot_scale(tz, den);
      px = clamp(ux + fxmul(uy, tz, FRAC_BITS) - fxmul(uz, ty, FRAC_BITS));
      py = clamp(uy + fxmul(uz, tx, FRAC_BITS) - fxmul(ux, tz, FRAC_BITS));
      pz = clamp(uz + fxmul(ux, ty, FRAC_BITS) - fxmul(uy, tx, FRAC_BITS));
      wx = clamp(ux + fxmul(py, sz, FRAC_BITS) - fxmul(pz, sy, FRAC_BITS));
      wy = clamp(uy + fxmul(pz, sx, FRAC_BITS) - fxmul(px, sz, FRAC_BITS));
      wz = clamp(uz + fxmul(px, sy, FRAC_BITS) - fxmul(py, sx, FRAC_BITS));
      nvx = clamp(wx + kx);
      nvy = clamp(wy + ky);
      nvz = clamp(wz + kz);
    end else begin
      nvx = clamp(pt.vx + fxmul(mdl_alpha, pt.ex, FRAC_BITS - 1));
      nvy = 64'(pt.vy);
      nvz = 64'(pt.vz);
    end
    p = pt.pos + fxmul(mdl_dt, nvx, FRAC_BITS);
    if (p < 0) p = -p;
    else if (p > mdl_len) p = 2 * mdl_len - p;
    r.tag = pt.tag & TAG_MASK;
    r.pos = 32'(clamp(p));
    r.vx = 32'(nvx);
    r.vy = 32'(nvy);
    r.vz = 32'(nvz);
    return r;
  endfunction

  // Write one register over the configuration channel and mirror it
  task automatic write_reg(input logic [7:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_MODE:  mdl_mode = val[0];
      CFG_ALPHA: mdl_alpha = 64'($signed(val));
      CFG_DT:    mdl_dt = {33'd0, val[30:0]};
      CFG_LEN:   mdl_len = {33'd0, val[30:0]};
      default: ;
    endcase
    // Hold the channel idle between writes
    @(posedge clk);
  endtask

  // Drain the pipeline before touching registers
  task automatic wait_idle();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (pushed_q.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (60) @(posedge clk);
  endtask

  task automatic send_particle(input particle_t pt);
    // Drop valid only while idling so back-to-back transfers keep it high
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_tag <= pt.tag;
    in_pos <= pt.pos;
    in_vel_x <= pt.vx;
    in_vel_y <= pt.vy;
    in_vel_z <= pt.vz;
    e_x <= pt.ex;
    e_y <= pt.ey;
    e_z <= pt.ez;
    b_x <= pt.bx;
    b_y <= pt.by;
    b_z <= pt.bz;
    do @(posedge clk); while (!in_ready);
    pushed_q.push_back(push_particle(pt));
    n_sent++;
  endtask

  function automatic logic signed [31:0] rand_val();
    case ($urandom_range(5))
      0: return $signed($urandom());
      1: return $signed($urandom_range(32'h0001_FFFF)) - 32'sh0001_0000;
      2: return $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
      default: return $signed($urandom_range(32'h00FF_FFFF)) - 32'sh0080_0000;
    endcase
  endfunction

  function automatic particle_t rand_particle();
    particle_t pt;
    pt.tag = 16'($urandom());
    pt.pos = $urandom_range(1) ? rand_val() : $signed($urandom_range(32'h0050_0000));
    pt.vx = rand_val();
    pt.vy = rand_val();
    pt.vz = rand_val();
    pt.ex = rand_val();
    pt.ey = rand_val();
    pt.ez = rand_val();
    pt.bx = rand_val();
    pt.by = rand_val();
    pt.bz = rand_val();
    return pt;
  endfunction

  // Extremes, reflections at both walls and saturation
  task automatic test_directed();
    particle_t pt;
    logic signed [31:0] ext[4];
    ext = '{32'sh7FFFFFFF, 32'sh80000000, 32'sh0, 32'sh0001_0000};
    for (int i = 0; i < 4; i++) begin
      pt.tag = (i == 0) ? 16'hFFFF : 16'(i);
      pt.pos = ext[i];
      pt.vx = ext[i];
      pt.vy = ext[(i + 1) % 4];
      pt.vz = ext[(i + 2) % 4];
      pt.ex = ext[(i + 3) % 4];
      pt.ey = ext[i];
      pt.ez = ext[(i + 1) % 4];
      pt.bx = ext[(i + 2) % 4];
      pt.by = ext[(i + 3) % 4];
      pt.bz = ext[i];
      send_particle(pt);
    end
    pt = '{default: 0};
    // Reflect below zero, then above the domain
    pt.pos = 32'sh0000_0100;
    pt.vx = -32'sh0010_0000;
    send_particle(pt);
    pt.pos = 32'sh003F_FF00;
    pt.vx = 32'sh0010_0000;
    send_particle(pt);
    pt.pos = 32'sh7FFF_0000;
    pt.vx = 32'sh7FFF_FFFF;
    send_particle(pt);
  endtask

  task automatic test_random(input int count);
    repeat (count) send_particle(rand_particle());
  endtask

  task automatic test_config_sweep();
    logic [31:0] alphas[5];
    alphas = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0CCD, 32'hFFFF_F000};
    for (int m = 0; m < 2; m++) begin
      for (int a = 0; a < 5; a++) begin
        wait_idle();
        write_reg(CFG_MODE, m);
        write_reg(CFG_ALPHA, alphas[a]);
        write_reg(CFG_DT, (a == 1) ? 32'h7FFF_FFFF : (a == 2) ? 32'h0 : $urandom());
        write_reg(CFG_LEN, (a == 2) ? 32'h7FFF_FFFF : (a == 0) ? 32'h0 : $urandom());
        // Out-of-range index must be ignored
        write_reg(8'd4 + 8'($urandom_range(250)), $urandom());
        if (a == 0) test_directed();
        test_random(40);
      end
    end
    wait_idle();
    write_reg(CFG_MODE, 32'd1);
    write_reg(CFG_ALPHA, 32'h0000_0CCD);
    write_reg(CFG_DT, 32'd6554);
    write_reg(CFG_LEN, 32'd4194304);
  endtask

  // Check each result transfer against the oldest prediction
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pushed_q.size() == 0) begin
          $error("result with no particle pending, tag %0h", out_tag);
          n_errors++;
        end else begin
          pushed_t e;
          e = pushed_q.pop_front();
          n_checked++;
          if (out_tag !== e.tag) begin
            $error("out_tag exp %0h got %0h", e.tag, out_tag);
            n_errors++;
          end
          if (new_pos !== e.pos) begin
            $error("new_pos exp %0d got %0d", e.pos, new_pos);
            n_errors++;
          end
          if (new_vel_x !== e.vx) begin
            $error("new_vel_x exp %0d got %0d", e.vx, new_vel_x);
            n_errors++;
          end
          if (new_vel_y !== e.vy) begin
            $error("new_vel_y exp %0d got %0d", e.vy, new_vel_y);
            n_errors++;
          end
          if (new_vel_z !== e.vz) begin
            $error("new_vel_z exp %0d got %0d", e.vz, new_vel_z);
            n_errors++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    n_sent = 0;
    n_checked = 0;
    n_errors = 0;
    mdl_mode = 1'b1;
    mdl_alpha = 0;
    mdl_dt = 6554;
    mdl_len = 4194304;
    send_idle_pct = 34;
    recv_idle_pct = 71;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Reset values first, then the register sweep
    test_directed();
    test_config_sweep();
    send_idle_pct = 71;
    recv_idle_pct = 34;
    test_random(250);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(250);
    wait_idle();
    $display("Pushed %0d particles, checked %0d results over both modes and extreme registers",
             n_sent, n_checked);
    if (n_errors == 0 && pushed_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
